[rtl/core/mkab_pkg.sv]
// Shared types and constants for the multi-key affine byte cipher.
`default_nettype none
package mkab_pkg;

   localparam int MAX_KEYS    = 16;
   localparam int SLOT_W      = $clog2(MAX_KEYS);
   localparam int KEY_COUNT_W = 5;
   localparam int BYTE_W      = 8;
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W = QUEUE_PTR_W + 1;

   localparam logic [1:0] FUNC_LOAD    = 2'd0;
   localparam logic [1:0] FUNC_ENCRYPT = 2'd1;
   localparam logic [1:0] FUNC_DECRYPT = 2'd2;

   typedef enum logic [1:0] {
      OP_LOAD,
      OP_ENCRYPT,
      OP_DECRYPT,
      OP_NOP
   } op_type;

   typedef struct packed {
      op_type              op;
      logic                mult_odd;
      logic                message_start;
      logic [SLOT_W-1:0]   key_slot;
      logic [BYTE_W-1:0]   data_byte;
      logic [BYTE_W-1:0]   key_mult;
      logic [BYTE_W-1:0]   key_add;
   } entry_type;

endpackage
`default_nettype wire

[rtl/core/mkab_front.sv]
// Front end: accepts request transactions, classifies them and queues them for the back end.
`default_nettype none
module mkab_front import mkab_pkg::*; (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire logic [1:0]        req_func,
   input  wire logic [BYTE_W-1:0] req_data_byte,
   input  wire logic              req_message_start,
   input  wire logic [SLOT_W-1:0] req_key_slot,
   input  wire logic [BYTE_W-1:0] req_key_mult,
   input  wire logic [BYTE_W-1:0] req_key_add,
   output logic                   q_valid,
   input  wire logic              q_ready,
   output entry_type              q_entry
);

   entry_type               queue_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_W-1:0]  count_ff, count_in;
   entry_type               new_entry;
   logic                    push;
   logic                    pop;

   always_comb begin
      new_entry.message_start = req_message_start;
      new_entry.key_slot      = req_key_slot;
      new_entry.data_byte     = req_data_byte;
      new_entry.key_mult      = req_key_mult;
      new_entry.key_add       = req_key_add;
      new_entry.mult_odd      = req_key_mult[0];
      unique case (req_func)
         FUNC_LOAD:    new_entry.op = OP_LOAD;
         FUNC_ENCRYPT: new_entry.op = OP_ENCRYPT;
         FUNC_DECRYPT: new_entry.op = OP_DECRYPT;
         default:      new_entry.op = OP_NOP;
      endcase
   end

   assign req_ready = (count_ff != QUEUE_CNT_W'(QUEUE_DEPTH));
   assign q_valid   = (count_ff != '0);
   assign q_entry   = queue_ff[rd_ptr_ff];
   assign push      = req_valid && req_ready;
   assign pop       = q_valid && q_ready;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + QUEUE_CNT_W'(push) - QUEUE_CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= new_entry;
      end
   end

endmodule
`default_nettype wire

[rtl/core/mkab_back.sv]
// Back end: key tables, key position, inverse sequencer and the response register.
`default_nettype none
module mkab_back import mkab_pkg::*; (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic [KEY_COUNT_W-1:0] key_count,
   input  wire logic                   q_valid,
   output logic                        q_ready,
   input  wire entry_type              q_entry,
   output logic                        back_busy,
   output logic                        rsp_valid,
   input  wire logic                   rsp_ready,
   output logic [BYTE_W-1:0]           rsp_out_byte,
   output logic                        rsp_key_error
);

   localparam logic ST_RUN = 1'b0;
   localparam logic ST_INV = 1'b1;
   localparam logic [2:0] LAST_BIT = 3'(BYTE_W - 1);

   logic [BYTE_W-1:0]      mult_table_ff [MAX_KEYS];
   logic [BYTE_W-1:0]      add_table_ff  [MAX_KEYS];
   logic [BYTE_W-1:0]      inv_table_ff  [MAX_KEYS];
   logic [SLOT_W-1:0]      key_pos_ff, key_pos_in;
   logic                   state_ff, state_in;
   logic [BYTE_W-1:0]      inv_x_ff, inv_x_in;
   logic [BYTE_W-1:0]      inv_p_ff, inv_p_in;
   logic [BYTE_W-1:0]      inv_a_ff, inv_a_in;
   logic [2:0]             inv_bit_ff, inv_bit_in;
   logic [SLOT_W-1:0]      inv_slot_ff, inv_slot_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [BYTE_W-1:0]      rsp_byte_ff, rsp_byte_in;
   logic                   rsp_err_ff, rsp_err_in;

   logic                   out_free;
   logic                   pop;
   logic                   inv_step;
   logic                   inv_done;
   logic [KEY_COUNT_W-1:0] eff_count;
   logic [SLOT_W-1:0]      use_pos;
   logic [KEY_COUNT_W-1:0] pos_plus;
   logic [SLOT_W-1:0]      next_pos;
   logic [BYTE_W-1:0]      sel_mult;
   logic [BYTE_W-1:0]      sel_add;
   logic [BYTE_W-1:0]      sel_inv;
   logic [BYTE_W-1:0]      diff;
   logic [2*BYTE_W-1:0]    enc_prod;
   logic [2*BYTE_W-1:0]    dec_prod;
   logic [BYTE_W-1:0]      x_step;
   logic [BYTE_W-1:0]      p_step;
   logic                   load_tables;
   logic                   write_inv;
   logic [SLOT_W-1:0]      inv_wr_slot;
   logic [BYTE_W-1:0]      inv_wr_data;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign q_ready   = (state_ff == ST_RUN) && out_free;
   assign pop       = q_valid && q_ready;
   assign inv_done  = (inv_bit_ff == LAST_BIT);
   assign inv_step  = (state_ff == ST_INV) && (!inv_done || out_free);
   assign back_busy = (state_ff == ST_INV);

   always_comb begin
      if (key_count == '0) begin
         eff_count = KEY_COUNT_W'(1);
      end else if (key_count > KEY_COUNT_W'(MAX_KEYS)) begin
         eff_count = KEY_COUNT_W'(MAX_KEYS);
      end else begin
         eff_count = key_count;
      end
      if (q_entry.message_start || ({1'b0, key_pos_ff} >= eff_count)) begin
         use_pos = '0;
      end else begin
         use_pos = key_pos_ff;
      end
      pos_plus = {1'b0, use_pos} + KEY_COUNT_W'(1);
      next_pos = (pos_plus >= eff_count) ? '0 : pos_plus[SLOT_W-1:0];
      sel_mult = mult_table_ff[use_pos];
      sel_add  = add_table_ff[use_pos];
      sel_inv  = inv_table_ff[use_pos];
      diff     = q_entry.data_byte - sel_add;
      enc_prod = {{BYTE_W{1'b0}}, q_entry.data_byte} * {{BYTE_W{1'b0}}, sel_mult};
      dec_prod = {{BYTE_W{1'b0}}, diff} * {{BYTE_W{1'b0}}, sel_inv};
   end

   // one bit of the inverse per cycle (the last bit waits for a free response register): fix bit i of a*x, keep p = a*x
   always_comb begin
      x_step = inv_x_ff;
      p_step = inv_p_ff;
      if (inv_p_ff[inv_bit_ff]) begin
         x_step = inv_x_ff | (BYTE_W'(1) << inv_bit_ff);
         p_step = inv_p_ff + (inv_a_ff << inv_bit_ff);
      end
   end

   always_comb begin
      state_in     = state_ff;
      key_pos_in   = key_pos_ff;
      inv_x_in     = inv_x_ff;
      inv_p_in     = inv_p_ff;
      inv_a_in     = inv_a_ff;
      inv_bit_in   = inv_bit_ff;
      inv_slot_in  = inv_slot_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_byte_in  = rsp_byte_ff;
      rsp_err_in   = rsp_err_ff;
      load_tables  = 1'b0;
      write_inv    = 1'b0;
      inv_wr_slot  = q_entry.key_slot;
      inv_wr_data  = '0;
      if (pop) begin
         unique case (q_entry.op)
            OP_LOAD: begin
               load_tables = 1'b1;
               if (q_entry.mult_odd) begin
                  state_in    = ST_INV;
                  inv_x_in    = BYTE_W'(1);
                  inv_p_in    = q_entry.key_mult;
                  inv_a_in    = q_entry.key_mult;
                  inv_bit_in  = 3'd1;
                  inv_slot_in = q_entry.key_slot;
               end else begin
                  write_inv    = 1'b1;
                  rsp_valid_in = 1'b1;
                  rsp_byte_in  = '0;
                  rsp_err_in   = 1'b1;
               end
            end
            OP_ENCRYPT: begin
               key_pos_in   = next_pos;
               rsp_valid_in = 1'b1;
               rsp_byte_in  = enc_prod[BYTE_W-1:0] + sel_add;
               rsp_err_in   = 1'b0;
            end
            OP_DECRYPT: begin
               key_pos_in   = next_pos;
               rsp_valid_in = 1'b1;
               rsp_byte_in  = dec_prod[BYTE_W-1:0];
               rsp_err_in   = 1'b0;
            end
            default: begin
               rsp_valid_in = 1'b1;
               rsp_byte_in  = '0;
               rsp_err_in   = 1'b0;
            end
         endcase
      end else if (inv_step) begin
         inv_x_in   = x_step;
         inv_p_in   = p_step;
         inv_bit_in = inv_bit_ff + 3'd1;
         if (inv_done) begin
            state_in     = ST_RUN;
            write_inv    = 1'b1;
            inv_wr_slot  = inv_slot_ff;
            inv_wr_data  = x_step;
            rsp_valid_in = 1'b1;
            rsp_byte_in  = '0;
            rsp_err_in   = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_RUN;
         key_pos_ff   <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < MAX_KEYS; i++) begin
            mult_table_ff[i] <= '0;
            add_table_ff[i]  <= '0;
            inv_table_ff[i]  <= '0;
         end
      end else begin
         state_ff     <= state_in;
         key_pos_ff   <= key_pos_in;
         rsp_valid_ff <= rsp_valid_in;
         if (load_tables) begin
            mult_table_ff[q_entry.key_slot] <= q_entry.key_mult;
            add_table_ff[q_entry.key_slot]  <= q_entry.key_add;
         end
         if (write_inv) begin
            inv_table_ff[inv_wr_slot] <= inv_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      inv_x_ff    <= inv_x_in;
      inv_p_ff    <= inv_p_in;
      inv_a_ff    <= inv_a_in;
      inv_bit_ff  <= inv_bit_in;
      inv_slot_ff <= inv_slot_in;
      rsp_byte_ff <= rsp_byte_in;
      rsp_err_ff  <= rsp_err_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_out_byte  = rsp_byte_ff;
   assign rsp_key_error = rsp_err_ff;

endmodule
`default_nettype wire

[rtl/core/multi_key_affine_byte_cipher.sv]
// Multi-key affine byte cipher: top level with the key count register.
//
// Request transactions (req_*) carry a key load, an encrypt byte or a
// decrypt byte; each yields exactly one response transaction (rsp_*), in
// order. Requests enter a four-entry queue in the front end; the back end
// takes one entry per cycle when its response register is free and no inverse is in progress.
// Encrypt, decrypt and even-multiplier loads: response valid in the cycle after
// the back end takes the entry, one per cycle sustained while rsp_ready is high.
// A load with an odd multiplier works out the inverse one bit per cycle in the
// back end's sequencer, the last bit only once the response register is free.
// csr_key_count is written through its own channel, always ready; write it
// only while no transaction is in flight.
// Reset (synchronous) clears the key tables, key position and queue and sets the
// key count to 1; no clearing pass is needed.
// When rsp_ready is low the response register holds its transaction, the back
// end stops and the queue fills; req_ready falls when the queue is full.
`default_nettype none
module multi_key_affine_byte_cipher import mkab_pkg::*; (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_ready,
   input  wire logic [1:0]             req_func,
   input  wire logic [BYTE_W-1:0]      req_data_byte,
   input  wire logic                   req_message_start,
   input  wire logic [SLOT_W-1:0]      req_key_slot,
   input  wire logic [BYTE_W-1:0]      req_key_mult,
   input  wire logic [BYTE_W-1:0]      req_key_add,
   output logic                        rsp_valid,
   input  wire logic                   rsp_ready,
   output logic [BYTE_W-1:0]           rsp_out_byte,
   output logic                        rsp_key_error,
   input  wire logic                   csr_valid,
   output logic                        csr_ready,
   input  wire logic [KEY_COUNT_W-1:0] csr_key_count
);

   logic [KEY_COUNT_W-1:0] key_count_ff, key_count_in;
   logic                   q_valid;
   logic                   q_ready;
   entry_type              q_entry;
   logic                   back_busy;

   assign csr_ready    = 1'b1;
   assign key_count_in = (csr_valid && csr_ready) ? csr_key_count : key_count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         key_count_ff <= KEY_COUNT_W'(1);
      end else begin
         key_count_ff <= key_count_in;
      end
   end

   mkab_front u_front (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_func          (req_func),
      .req_data_byte     (req_data_byte),
      .req_message_start (req_message_start),
      .req_key_slot      (req_key_slot),
      .req_key_mult      (req_key_mult),
      .req_key_add       (req_key_add),
      .q_valid           (q_valid),
      .q_ready           (q_ready),
      .q_entry           (q_entry)
   );

   mkab_back u_back (
      .clock         (clock),
      .reset         (reset),
      .key_count     (key_count_ff),
      .q_valid       (q_valid),
      .q_ready       (q_ready),
      .q_entry       (q_entry),
      .back_busy     (back_busy),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_out_byte  (rsp_out_byte),
      .rsp_key_error (rsp_key_error)
   );

   a_err_zero_byte: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_key_error) |-> (rsp_out_byte == '0))
      else $error("key error response with non-zero byte");

   a_full_has_entry: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> q_valid)
      else $error("queue full but nothing to take");

   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> ($past(q_valid) || $past(back_busy)))
      else $error("response without a queued transaction");

   a_no_pop_busy: assert property (@(posedge clock) disable iff (reset)
      back_busy |-> !q_ready)
      else $error("queue popped during inverse sequence");

endmodule
`default_nettype wire

[tb/sv/tb.sv]
// Self-checking testbench for the multi-key affine byte cipher.
module tb import mkab_pkg::*; ();

   localparam int IDLE_PCT = 14;
   localparam int STALL_LIMIT = 1000;

   typedef enum logic [1:0] {
      ACT_REQUEST,
      ACT_KEY_COUNT,
      ACT_DRAIN
   } act_kind_type;

   typedef struct {
      op_type              op;
      logic [BYTE_W-1:0]   data_byte;
      logic                message_start;
      logic [SLOT_W-1:0]   key_slot;
      logic [BYTE_W-1:0]   key_mult;
      logic [BYTE_W-1:0]   key_add;
   } cipher_req_type;

   typedef struct {
      act_kind_type           kind;
      cipher_req_type         req;
      logic [KEY_COUNT_W-1:0] key_count;
      bit                     may_idle;
   } cipher_act_type;

   typedef struct {
      logic [BYTE_W-1:0] out_byte;
      logic              key_error;
   } cipher_rsp_type;

   logic                   clock;
   logic                   reset;
   logic                   req_valid;
   logic                   req_ready;
   logic [1:0]             req_func;
   logic [BYTE_W-1:0]      req_data_byte;
   logic                   req_message_start;
   logic [SLOT_W-1:0]      req_key_slot;
   logic [BYTE_W-1:0]      req_key_mult;
   logic [BYTE_W-1:0]      req_key_add;
   logic                   rsp_valid;
   logic                   rsp_ready;
   logic [BYTE_W-1:0]      rsp_out_byte;
   logic                   rsp_key_error;
   logic                   csr_valid;
   logic                   csr_ready;
   logic [KEY_COUNT_W-1:0] csr_key_count;

   multi_key_affine_byte_cipher dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_func          (req_func),
      .req_data_byte     (req_data_byte),
      .req_message_start (req_message_start),
      .req_key_slot      (req_key_slot),
      .req_key_mult      (req_key_mult),
      .req_key_add       (req_key_add),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_out_byte      (rsp_out_byte),
      .rsp_key_error     (rsp_key_error),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_key_count     (csr_key_count)
   );

   cipher_act_type act_q[$];
   cipher_rsp_type rsp_expect[$];

   logic [BYTE_W-1:0]      mult_tbl [MAX_KEYS];
   logic [BYTE_W-1:0]      add_tbl [MAX_KEYS];
   logic [BYTE_W-1:0]      inv_tbl [MAX_KEYS];
   int                     key_pos;
   logic [KEY_COUNT_W-1:0] key_count_q;

   logic req_taken;
   logic csr_taken;
   bit   gap_allowed;
   int   fails;
   int   n_req, n_rsp, n_csr, n_even, n_enc, n_dec, n_nop;

   // affine step on the shadow key tables
   function automatic cipher_rsp_type cipher_step(input cipher_req_type r);
      cipher_rsp_type res;
      int          cnt;
      int          p;
      logic [BYTE_W-1:0] inv;
      res.out_byte = '0;
      res.key_error = 1'b0;
      cnt = (key_count_q == 0) ? 1 : (key_count_q > MAX_KEYS) ? MAX_KEYS : int'(key_count_q);
      case (r.op)
         OP_LOAD: begin
            inv = '0;
            if (r.key_mult[0]) begin
               for (int x = 1; x < 256; x += 2)
                  if (8'(r.key_mult * x) == 8'd1) inv = 8'(x);
            end
            mult_tbl[r.key_slot] = r.key_mult;
            add_tbl[r.key_slot] = r.key_add;
            inv_tbl[r.key_slot] = inv;
            res.key_error = ~r.key_mult[0];
         end
         OP_ENCRYPT, OP_DECRYPT: begin
            p = (r.message_start || key_pos >= cnt) ? 0 : key_pos;
            if (r.op == OP_ENCRYPT)
               res.out_byte = r.data_byte * mult_tbl[p] + add_tbl[p];
            else
               res.out_byte = (r.data_byte - add_tbl[p]) * inv_tbl[p];
            key_pos = (p + 1 >= cnt) ? 0 : p + 1;
         end
         default: ;
      endcase
      return res;
   endfunction

   task automatic push_req(input op_type op, input logic [7:0] data, input logic start,
                           input logic [3:0] slot, input logic [7:0] mult,
                           input logic [7:0] addv);
      cipher_act_type a;
      a.kind = ACT_REQUEST;
      a.req.op = op;
      a.req.data_byte = data;
      a.req.message_start = start;
      a.req.key_slot = slot;
      a.req.key_mult = mult;
      a.req.key_add = addv;
      a.key_count = '0;
      a.may_idle = gap_allowed;
      act_q.push_back(a);
   endtask

   task automatic push_ctrl(input act_kind_type kind, input logic [4:0] kc);
      cipher_act_type a;
      a.kind = kind;
      a.req.op = OP_NOP;
      a.req.data_byte = '0;
      a.req.message_start = 1'b0;
      a.req.key_slot = '0;
      a.req.key_mult = '0;
      a.req.key_add = '0;
      a.key_count = kc;
      a.may_idle = 1'b0;
      act_q.push_back(a);
   endtask

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_func = '0;
      req_data_byte = '0;
      req_message_start = 1'b0;
      req_key_slot = '0;
      req_key_mult = '0;
      req_key_add = '0;
      rsp_ready = 1'b0;
      csr_valid = 1'b0;
      csr_key_count = '0;
      for (int i = 0; i < MAX_KEYS; i++) begin
         mult_tbl[i] = '0;
         add_tbl[i] = '0;
         inv_tbl[i] = '0;
      end
      key_pos = 0;
      key_count_q = 5'd1;
   end

   // driver: request and key-count channels, changed on the falling edge
   always @(negedge clock) begin : drive
      cipher_act_type a;
      logic        next_req;
      logic        next_csr;
      if (reset) begin
         req_valid <= 1'b0;
         csr_valid <= 1'b0;
      end else if (!(req_valid && !req_taken) && !(csr_valid && !csr_taken)) begin
         next_req = 1'b0;
         next_csr = 1'b0;
         if (act_q.size() != 0) begin
            a = act_q[0];
            case (a.kind)
               ACT_REQUEST: begin
                  if (!a.may_idle || $urandom_range(99) >= IDLE_PCT) begin
                     req_func <= a.req.op;
                     req_data_byte <= a.req.data_byte;
                     req_message_start <= a.req.message_start;
                     req_key_slot <= a.req.key_slot;
                     req_key_mult <= a.req.key_mult;
                     req_key_add <= a.req.key_add;
                     next_req = 1'b1;
                     void'(act_q.pop_front());
                  end
               end
               ACT_KEY_COUNT: begin
                  if (rsp_expect.size() == 0) begin
                     csr_key_count <= a.key_count;
                     next_csr = 1'b1;
                     void'(act_q.pop_front());
                  end
               end
               default: begin
                  if (rsp_expect.size() == 0) void'(act_q.pop_front());
               end
            endcase
         end
         req_valid <= next_req;
         csr_valid <= next_csr;
      end
   end

   always @(negedge clock) begin : sink
      if (reset)
         rsp_ready <= 1'b0;
      else if (n_rsp >= 450 && n_rsp < 750)
         rsp_ready <= 1'b1;
      else
         rsp_ready <= $urandom_range(99) >= IDLE_PCT;
   end

   // monitor: prediction on accepted requests, checking on accepted responses
   always @(posedge clock) begin : observe
      cipher_rsp_type want;
      cipher_req_type got;
      if (reset) begin
         req_taken <= 1'b0;
         csr_taken <= 1'b0;
      end else begin
         req_taken <= req_valid && req_ready;
         csr_taken <= csr_valid && csr_ready;
         if (rsp_valid && rsp_ready) begin
            n_rsp++;
            if (rsp_expect.size() == 0) begin
               $error("unexpected response: out_byte %02h key_error %0b",
                      rsp_out_byte, rsp_key_error);
               fails++;
            end else begin
               want = rsp_expect.pop_front();
               if (rsp_out_byte !== want.out_byte) begin
                  $error("out_byte: expected %02h, got %02h", want.out_byte, rsp_out_byte);
                  fails++;
               end
               if (rsp_key_error !== want.key_error) begin
                  $error("key_error: expected %0b, got %0b", want.key_error, rsp_key_error);
                  fails++;
               end
            end
         end
         if (csr_valid && csr_ready) begin
            key_count_q = csr_key_count;
            n_csr++;
         end
         if (req_valid && req_ready) begin
            got.op = op_type'(req_func);
            got.data_byte = req_data_byte;
            got.message_start = req_message_start;
            got.key_slot = req_key_slot;
            got.key_mult = req_key_mult;
            got.key_add = req_key_add;
            case (got.op)
               OP_LOAD:    if (!got.key_mult[0]) n_even++;
               OP_ENCRYPT: n_enc++;
               OP_DECRYPT: n_dec++;
               default:    n_nop++;
            endcase
            rsp_expect.push_back(cipher_step(got));
            n_req++;
         end
      end
   end

   always @(posedge clock) begin : watchdog
      int quiet;
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)
          || (csr_valid && csr_ready)) begin
         quiet = 0;
      end else begin
         quiet++;
         if (quiet >= STALL_LIMIT) begin
            $error("no transaction for %0d cycles", STALL_LIMIT);
            $display("FAIL multi_key_affine_byte_cipher");
            $finish;
         end
      end
   end

   initial begin : stimulus
      int                     nk;
      int                     len;
      int                     issued;
      int                     sel;
      logic [KEY_COUNT_W-1:0] kc;
      logic [BYTE_W-1:0]      m;
      op_type                 op;

      fails = 0;
      gap_allowed = 1'b1;

      // directed: extremes, every func, even multipliers, count edge cases
      push_ctrl(ACT_KEY_COUNT, 5'd16);
      push_req(OP_ENCRYPT, 8'h7E, 1'b1, 4'd0, 8'h00, 8'h00);
      push_req(OP_LOAD, 8'hFF, 1'b1, 4'd0, 8'h01, 8'h00);
      push_req(OP_LOAD, 8'h00, 1'b0, 4'd1, 8'hFF, 8'hFF);
      push_req(OP_LOAD, 8'h00, 1'b0, 4'd2, 8'h00, 8'h80);
      push_req(OP_LOAD, 8'h00, 1'b0, 4'd15, 8'hFE, 8'h7F);
      push_req(OP_ENCRYPT, 8'h00, 1'b1, 4'd0, 8'h00, 8'h00);
      push_req(OP_DECRYPT, 8'hFF, 1'b0, 4'd0, 8'h00, 8'h00);
      push_req(OP_DECRYPT, 8'h5A, 1'b0, 4'd0, 8'h00, 8'h00);
      push_req(OP_ENCRYPT, 8'hFF, 1'b0, 4'd0, 8'h00, 8'h00);
      push_req(OP_NOP, 8'hFF, 1'b1, 4'd15, 8'hFF, 8'hFF);
      push_req(OP_ENCRYPT, 8'hA5, 1'b0, 4'hF, 8'hFF, 8'hFF);
      // lower the count with the position beyond it
      push_ctrl(ACT_KEY_COUNT, 5'd2);
      push_req(OP_ENCRYPT, 8'h80, 1'b0, 4'd0, 8'h00, 8'h00);
      push_req(OP_DECRYPT, 8'h01, 1'b0, 4'd0, 8'h00, 8'h00);
      push_ctrl(ACT_KEY_COUNT, 5'd0);
      push_req(OP_ENCRYPT, 8'h33, 1'b0, 4'd0, 8'h00, 8'h00);
      push_req(OP_DECRYPT, 8'h33, 1'b1, 4'd0, 8'h00, 8'h00);
      push_ctrl(ACT_KEY_COUNT, 5'd31);
      push_req(OP_LOAD, 8'h00, 1'b0, 4'd15, 8'h81, 8'h01);
      push_req(OP_ENCRYPT, 8'hC3, 1'b1, 4'd0, 8'h00, 8'h00);
      push_req(OP_DECRYPT, 8'h3C, 1'b0, 4'd0, 8'h00, 8'h00);

      // random phases, each under its own key count
      for (int ph = 0; ph < 10; ph++) begin
         gap_allowed = !(ph == 4 || ph == 5);
         case (ph)
            0:       kc = 5'd0;
            1:       kc = 5'd31;
            2:       kc = 5'd16;
            3:       kc = 5'd1;
            7:       kc = 5'($urandom_range(17, 30));
            default: kc = 5'($urandom_range(1, 16));
         endcase
         push_ctrl(ACT_KEY_COUNT, kc);
         nk = (kc == 0) ? 1 : (kc > MAX_KEYS) ? MAX_KEYS : int'(kc);
         issued = 0;
         while (issued < 125) begin
            sel = $urandom_range(99);
            if (sel < 15) begin
               push_req(op_type'($urandom_range(3)), 8'($urandom), 1'($urandom),
                        4'($urandom), 8'($urandom), 8'($urandom));
               issued++;
            end else if (sel < 22) begin
               // message carried on without a fresh start
               len = $urandom_range(1, 6);
               for (int i = 0; i < len; i++) begin
                  op = $urandom_range(1) ? OP_ENCRYPT : OP_DECRYPT;
                  push_req(op, 8'($urandom), 1'b0, 4'($urandom), 8'($urandom),
                           8'($urandom));
               end
               issued += len;
            end else begin
               for (int k = 0; k < nk; k++) begin
                  if ($urandom_range(3) == 0) begin
                     m = 8'($urandom);
                     if ($urandom_range(9) != 0) m[0] = 1'b1;
                     push_req(OP_LOAD, 8'($urandom), 1'($urandom), 4'(k), m, 8'($urandom));
                     issued++;
                  end
               end
               len = $urandom_range(1, 2 * nk + 4);
               op = $urandom_range(1) ? OP_ENCRYPT : OP_DECRYPT;
               for (int i = 0; i < len; i++) begin
                  if ($urandom_range(4) == 0) op = $urandom_range(1) ? OP_ENCRYPT : OP_DECRYPT;
                  push_req(op, 8'($urandom), i == 0, 4'($urandom), 8'($urandom),
                           8'($urandom));
               end
               issued += len;
            end
         end
         if (ph == 6) push_ctrl(ACT_DRAIN, '0);
      end

      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (act_q.size() != 0 || req_valid || csr_valid || rsp_expect.size() != 0)
         @(posedge clock);
      repeat (20) @(posedge clock);

      $display("%0d requests, %0d responses, %0d key-count writes", n_req, n_rsp, n_csr);
      $display("encrypts %0d, decrypts %0d, even-multiplier loads %0d, unused func %0d",
               n_enc, n_dec, n_even, n_nop);
      if (fails == 0)
         $display("PASS multi_key_affine_byte_cipher");
      else
         $display("FAIL multi_key_affine_byte_cipher");
      $finish;
   end

endmodule
